// ----- hw/rtl/ring_neighbour_mean_filter_macros.svh -----
// Assertion macros used by the top level of the ring neighbour mean filter RTL.
`ifndef RING_NEIGHBOUR_MEAN_FILTER_MACROS_SVH
`define RING_NEIGHBOUR_MEAN_FILTER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RNMF_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rnmf assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define RNMF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rnmf assertion failed");

`endif

// ----- hw/rtl/rnmf_pkg.sv -----
// Package with types, constants and helper functions of the ring neighbour mean filter.
package rnmf_pkg;

    localparam int PIXEL_BITS    = 16;
    localparam int MAX_DEPTH_DEF = 4;
    localparam int MAX_FRAME_DEF = 256;
    localparam int DEPTH_REG_W   = 3;
    localparam int SIZE_REG_W    = 9;
    localparam int POS_W         = 8;
    localparam int NBR_COUNT     = 8;
    localparam int NBR_SHIFT     = 3;
    localparam int CFG_DATA_W    = 32;
    localparam int CFG_ADDR_W    = 3;

    localparam logic REG_RING_DEPTH = 1'b0;
    localparam logic REG_FRAME_SIZE = 1'b1;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef struct packed {
        logic                         operation;
        logic signed [PIXEL_BITS-1:0] pixel;
    } t_in_item;

    typedef struct packed {
        logic signed [PIXEL_BITS-1:0] mean_value;
        logic [POS_W-1:0]             centre_row;
        logic [POS_W-1:0]             centre_col;
        logic                         frame_last;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DRAIN,
        ST_DIV,
        ST_WAIT,
        ST_DONE
    } t_state;

    function automatic logic signed [1:0] nbr_dr(input logic [NBR_SHIFT-1:0] j);
        logic signed [1:0] v;
        case (j)
            3'd0, 3'd1, 3'd2: v = -2'sd1;
            3'd3, 3'd4:       v = 2'sd0;
            default:          v = 2'sd1;
        endcase
        return v;
    endfunction

    function automatic logic signed [1:0] nbr_dc(input logic [NBR_SHIFT-1:0] j);
        logic signed [1:0] v;
        case (j)
            3'd0, 3'd3, 3'd5: v = -2'sd1;
            3'd1, 3'd6:       v = 2'sd0;
            default:          v = 2'sd1;
        endcase
        return v;
    endfunction

endpackage

// ----- hw/rtl/rnmf_line_store.sv -----
// Synchronous line store memory with one write port and one registered read port.
module rnmf_line_store #(
    parameter int ROWS   = 10,
    parameter int COLS_W = 8,
    parameter int DATA_W = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_wr_en,
    input  logic [$clog2(ROWS*(2**COLS_W))-1:0]      i_wr_addr,
    input  logic [DATA_W-1:0]                        i_wr_data,
    input  logic                                     i_rd_en,
    input  logic [$clog2(ROWS*(2**COLS_W))-1:0]      i_rd_addr,
    output logic [DATA_W-1:0]                        o_rd_data
);

    localparam int DEPTH = ROWS * (2**COLS_W);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hw/rtl/rnmf_divider.sv -----
// Serial restoring divider that produces one quotient bit per cycle.
module rnmf_divider #(
    parameter int QW = 16,
    parameter int DW = 3
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [QW+DW-1:0] i_dividend,
    input  logic [DW-1:0]    i_divisor,
    output logic             o_done,
    output logic [QW-1:0]    o_quotient
);

    localparam int CNT_W = $clog2(QW + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DW-1:0]    r_rem;
    logic [QW-1:0]    r_low;
    logic [DW-1:0]    r_div;
    logic [DW:0]      w_trial;
    logic [DW:0]      w_diff;
    logic             w_bit;
    logic [DW-1:0]    w_rem;

    always_comb begin
        w_trial = {r_rem, r_low[QW-1]};
        w_diff  = w_trial - {1'b0, r_div};
        w_bit   = (w_trial >= {1'b0, r_div});
        w_rem   = w_bit ? w_diff[DW-1:0] : w_trial[DW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(QW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[QW+DW-1:QW];
            r_low <= i_dividend[QW-1:0];
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_rem;
            r_low <= {r_low[QW-2:0], w_bit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_low;

endmodule

// ----- hw/rtl/ring_neighbour_mean_filter.sv -----
// Top level of the ring neighbour mean filter: registers, counters, sequencer and output stage.
//
//   Channel  Direction  Handshake                 Payload
//   in       input      i_in_valid / o_in_ready   i_in_data (rnmf_pkg::t_in_item)
//   out      output     o_out_valid / i_out_ready o_out_data (rnmf_pkg::t_out_item)
//   cfg      input      psel, penable, pwrite     paddr, pwdata, prdata, pready
//
// An item that gives no result is taken and the block stays ready. An item that gives a result
// takes line store reads of the eight neighbours on each ring up to depth (one read port, one
// neighbour per cycle), a drain state to settle the sum, the serial divider and a load of the
// output register before the next item can be taken. Reset is synchronous and needs no clearing
// pass. A stalled output holds its result; the block still takes items and computes one more
// result, which waits until the output register is free.
`include "ring_neighbour_mean_filter_macros.svh"

module ring_neighbour_mean_filter #(
    parameter int MAX_DEPTH = rnmf_pkg::MAX_DEPTH_DEF,
    parameter int MAX_FRAME = rnmf_pkg::MAX_FRAME_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  rnmf_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output rnmf_pkg::t_out_item                 o_out_data,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rnmf_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [rnmf_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [rnmf_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int PB   = rnmf_pkg::PIXEL_BITS;
    localparam int RING = 2 * MAX_DEPTH + 2;
    localparam int SLW  = $clog2(RING);
    localparam int CW   = $clog2(MAX_FRAME);
    localparam int RW   = $clog2(MAX_FRAME + 1);
    localparam int DW   = $clog2(MAX_DEPTH + 1);
    localparam int SUMW = PB + $clog2(rnmf_pkg::NBR_COUNT * MAX_DEPTH) + 1;
    localparam int AW   = SLW + CW;
    localparam int JW   = rnmf_pkg::NBR_SHIFT;

    rnmf_pkg::t_state r_state, n_state;

    logic [rnmf_pkg::DEPTH_REG_W-1:0] r_ring_depth;
    logic [rnmf_pkg::SIZE_REG_W-1:0]  r_frame_size;

    logic [RW-1:0]  r_in_row, n_in_row, r_out_row, n_out_row;
    logic [CW-1:0]  r_in_col, n_in_col, r_out_col, n_out_col;
    logic [SLW-1:0] r_in_slot, n_in_slot, r_out_slot, n_out_slot;

    logic [CW-1:0]  r_e_row, r_e_col;
    logic [SLW-1:0] r_e_slot;
    logic           r_e_last;
    logic [DW-1:0]  r_k;
    logic [JW-1:0]  r_j;
    logic           r_rd_vld;
    logic signed [SUMW-1:0] r_sum;
    logic           r_neg;
    logic           r_out_vld;
    rnmf_pkg::t_out_item r_out_data;

    logic [RW-1:0]  w_size;
    logic [DW-1:0]  w_depth;
    logic           w_cfg_wr;
    logic           w_acc;
    logic           w_is_flush;
    logic           w_wr_en;
    logic           w_emit;
    logic           w_last;
    logic           w_rd_en;
    logic           w_in_frame;
    logic           w_read_end;
    logic [AW-1:0]  w_rd_addr;
    logic signed [PB-1:0] w_rd_data;
    logic           w_div_start;
    logic           w_div_done;
    logic [PB-1:0]  w_quot;
    logic [SUMW-1:0] w_mag;
    logic           w_out_load;

    // Configuration registers.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_depth <= rnmf_pkg::DEPTH_REG_W'(1);
            r_frame_size <= rnmf_pkg::SIZE_REG_W'(256);
        end else if (w_cfg_wr) begin
            case (paddr[2])
                rnmf_pkg::REG_RING_DEPTH:
                    r_ring_depth <= pwdata[rnmf_pkg::DEPTH_REG_W-1:0];
                rnmf_pkg::REG_FRAME_SIZE:
                    r_frame_size <= pwdata[rnmf_pkg::SIZE_REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            rnmf_pkg::REG_RING_DEPTH: prdata = rnmf_pkg::CFG_DATA_W'(r_ring_depth);
            rnmf_pkg::REG_FRAME_SIZE: prdata = rnmf_pkg::CFG_DATA_W'(r_frame_size);
            default:                  prdata = '0;
        endcase
    end

    always_comb begin
        if (r_frame_size == '0) begin
            w_size = RW'(1);
        end else if (int'(r_frame_size) > MAX_FRAME) begin
            w_size = RW'(MAX_FRAME);
        end else begin
            w_size = RW'(r_frame_size);
        end
        if (r_ring_depth == '0) begin
            w_depth = DW'(1);
        end else if (int'(r_ring_depth) > MAX_DEPTH) begin
            w_depth = DW'(MAX_DEPTH);
        end else begin
            w_depth = DW'(r_ring_depth);
        end
    end

    // Frame position counters.
    assign w_acc      = i_in_valid && o_in_ready;
    assign w_is_flush = (i_in_data.operation == rnmf_pkg::OP_FLUSH);
    assign w_wr_en    = w_acc && !w_is_flush && (r_in_row < w_size);
    assign w_last     = (int'(r_out_row) == int'(w_size) - 1)
                     && (int'(r_out_col) == int'(w_size) - 1);

    always_comb begin
        if (w_is_flush) begin
            w_emit = w_acc && (r_in_row >= w_size) && (r_out_row < w_size);
        end else begin
            w_emit = w_acc && (r_in_row < w_size) && (int'(r_in_row) >= int'(w_depth) + 1);
        end
    end

    always_comb begin
        n_in_row   = r_in_row;
        n_in_col   = r_in_col;
        n_in_slot  = r_in_slot;
        n_out_row  = r_out_row;
        n_out_col  = r_out_col;
        n_out_slot = r_out_slot;
        if (w_wr_en) begin
            if (int'(r_in_col) + 1 >= int'(w_size)) begin
                n_in_col  = '0;
                n_in_row  = r_in_row + 1'b1;
                n_in_slot = (r_in_slot == SLW'(RING - 1)) ? '0 : r_in_slot + 1'b1;
            end else begin
                n_in_col = r_in_col + 1'b1;
            end
        end
        if (w_emit) begin
            if (w_last) begin
                n_in_row   = '0;
                n_in_col   = '0;
                n_in_slot  = '0;
                n_out_row  = '0;
                n_out_col  = '0;
                n_out_slot = '0;
            end else if (int'(r_out_col) + 1 >= int'(w_size)) begin
                n_out_col  = '0;
                n_out_row  = r_out_row + 1'b1;
                n_out_slot = (r_out_slot == SLW'(RING - 1)) ? '0 : r_out_slot + 1'b1;
            end else begin
                n_out_col = r_out_col + 1'b1;
            end
        end
        if (w_cfg_wr) begin
            n_in_row   = '0;
            n_in_col   = '0;
            n_in_slot  = '0;
            n_out_row  = '0;
            n_out_col  = '0;
            n_out_slot = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_row   <= '0;
            r_in_col   <= '0;
            r_in_slot  <= '0;
            r_out_row  <= '0;
            r_out_col  <= '0;
            r_out_slot <= '0;
        end else begin
            r_in_row   <= n_in_row;
            r_in_col   <= n_in_col;
            r_in_slot  <= n_in_slot;
            r_out_row  <= n_out_row;
            r_out_col  <= n_out_col;
            r_out_slot <= n_out_slot;
        end
    end

    // Neighbour address generation.
    always_comb begin
        int rr;
        int cc;
        int t;
        logic signed [1:0] dr;
        logic signed [1:0] dc;
        dr = rnmf_pkg::nbr_dr(r_j);
        dc = rnmf_pkg::nbr_dc(r_j);
        rr = int'(r_e_row) + int'(dr) * int'(r_k);
        cc = int'(r_e_col) + int'(dc) * int'(r_k);
        t  = int'(r_e_slot) + RING + int'(dr) * int'(r_k);
        if (t >= RING) begin
            t = t - RING;
        end
        if (t >= RING) begin
            t = t - RING;
        end
        w_in_frame = (rr >= 0) && (rr < int'(w_size)) && (cc >= 0) && (cc < int'(w_size));
        w_rd_addr  = {SLW'(t), CW'(cc)};
    end

    assign w_read_end = (r_k == w_depth) && (r_j == JW'(rnmf_pkg::NBR_COUNT - 1));

    // Sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            rnmf_pkg::ST_IDLE:  if (w_emit) n_state = rnmf_pkg::ST_READ;
            rnmf_pkg::ST_READ:  if (w_read_end) n_state = rnmf_pkg::ST_DRAIN;
            rnmf_pkg::ST_DRAIN: n_state = rnmf_pkg::ST_DIV;
            rnmf_pkg::ST_DIV:   n_state = rnmf_pkg::ST_WAIT;
            rnmf_pkg::ST_WAIT:  if (w_div_done) n_state = rnmf_pkg::ST_DONE;
            rnmf_pkg::ST_DONE:  if (!r_out_vld || i_out_ready) n_state = rnmf_pkg::ST_IDLE;
            default:            n_state = rnmf_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = (r_state == rnmf_pkg::ST_IDLE);
        w_rd_en     = (r_state == rnmf_pkg::ST_READ) && w_in_frame;
        w_div_start = (r_state == rnmf_pkg::ST_DIV);
        w_out_load  = (r_state == rnmf_pkg::ST_DONE) && (!r_out_vld || i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= rnmf_pkg::ST_IDLE;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= w_rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_e_row  <= r_out_row[CW-1:0];
            r_e_col  <= r_out_col;
            r_e_slot <= r_out_slot;
            r_e_last <= w_last;
            r_k      <= DW'(1);
            r_j      <= '0;
            r_sum    <= '0;
        end else begin
            if (r_state == rnmf_pkg::ST_READ) begin
                r_j <= r_j + 1'b1;
                if (r_j == JW'(rnmf_pkg::NBR_COUNT - 1)) begin
                    r_k <= r_k + 1'b1;
                end
            end
            if (r_rd_vld) begin
                r_sum <= r_sum + SUMW'(w_rd_data);
            end
        end
        if (w_div_start) begin
            r_neg <= r_sum[SUMW-1];
        end
    end

    assign w_mag = r_sum[SUMW-1] ? (~r_sum + 1'b1) : r_sum;

    rnmf_line_store #(
        .ROWS   (RING),
        .COLS_W (CW),
        .DATA_W (PB)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr ({r_in_slot, r_in_col}),
        .i_wr_data (i_in_data.pixel),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    rnmf_divider #(
        .QW (PB),
        .DW (DW)
    ) u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend ((PB + DW)'(w_mag >> rnmf_pkg::NBR_SHIFT)),
        .i_divisor  (w_depth),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_data.mean_value <= r_neg ? (~w_quot + 1'b1) : w_quot;
            r_out_data.centre_row <= rnmf_pkg::POS_W'(r_e_row);
            r_out_data.centre_col <= rnmf_pkg::POS_W'(r_e_col);
            r_out_data.frame_last <= r_e_last;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_data;

    `RNMF_ASSERT_SAME(a_out_behind_in, 1'b1, r_out_row <= r_in_row)
    `RNMF_ASSERT_SAME(a_load_after_div, w_out_load, w_div_done)
    `RNMF_ASSERT_NEXT(a_emit_starts_read, w_emit, r_state == rnmf_pkg::ST_READ)
    `RNMF_ASSERT_SAME(a_slots_in_ring, 1'b1, (int'(r_in_slot) < RING) && (int'(r_out_slot) < RING))

endmodule

// ----- tb/ring_neighbour_mean_filter_tb.sv -----
// Self-checking testbench for the ring neighbour mean filter with a built-in predictor.
`timescale 1ns / 100ps

module ring_neighbour_mean_filter_tb;

    localparam int RING_ROWS = 2 * rnmf_pkg::MAX_DEPTH_DEF + 2;
    localparam int WATCH_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 80;
    localparam int ITEM_TARGET = 1300;
    localparam logic [rnmf_pkg::CFG_ADDR_W-1:0] ADDR_RING_DEPTH =
        {rnmf_pkg::REG_RING_DEPTH, 2'b00};
    localparam logic [rnmf_pkg::CFG_ADDR_W-1:0] ADDR_FRAME_SIZE =
        {rnmf_pkg::REG_FRAME_SIZE, 2'b00};

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    rnmf_pkg::t_in_item i_in_data;
    logic o_out_valid;
    logic i_out_ready;
    rnmf_pkg::t_out_item o_out_data;
    logic psel;
    logic penable;
    logic pwrite;
    logic [rnmf_pkg::CFG_ADDR_W-1:0] paddr;
    logic [rnmf_pkg::CFG_DATA_W-1:0] pwdata;
    logic [rnmf_pkg::CFG_DATA_W-1:0] prdata;
    logic pready;

    ring_neighbour_mean_filter dut (.*);

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Predictor state.
    shortint line_rows [RING_ROWS][rnmf_pkg::MAX_FRAME_DEF];
    int unsigned in_row, in_col, out_row, out_col;
    logic [rnmf_pkg::DEPTH_REG_W-1:0] depth_reg;
    logic [rnmf_pkg::SIZE_REG_W-1:0] size_reg;
    bit frame_done;

    rnmf_pkg::t_out_item pending_means[$];
    int errors = 0;
    int idle_cycles = 0;
    int n_items;
    int ready_wait;
    bit calm;

    typedef struct {
        bit is_cfg;
        logic [rnmf_pkg::CFG_ADDR_W-1:0] addr;
        int unsigned value;
        rnmf_pkg::t_in_item item;
        bit typed;
        bit has_res;
        rnmf_pkg::t_out_item res;
    } t_row;

    localparam rnmf_pkg::t_out_item NO_RES = '{16'sd0, 8'd0, 8'd0, 1'b0};
    localparam rnmf_pkg::t_out_item SINGLE = '{16'sd0, 8'd0, 8'd0, 1'b1};

    t_row directed [] = '{
        '{1, ADDR_FRAME_SIZE, 1, '{rnmf_pkg::OP_PIXEL, 16'sd0}, 0, 0, NO_RES},
        '{1, ADDR_RING_DEPTH, 0, '{rnmf_pkg::OP_PIXEL, 16'sd0}, 0, 0, NO_RES},
        '{0, '0, 0, '{rnmf_pkg::OP_FLUSH, 16'sd0}, 1, 0, NO_RES},
        '{0, '0, 0, '{rnmf_pkg::OP_PIXEL, 16'sh7fff}, 1, 0, NO_RES},
        '{0, '0, 0, '{rnmf_pkg::OP_PIXEL, -16'sh8000}, 1, 0, NO_RES},
        '{0, '0, 0, '{rnmf_pkg::OP_FLUSH, 16'shffff}, 1, 1, SINGLE},
        '{0, '0, 0, '{rnmf_pkg::OP_FLUSH, 16'sd0}, 1, 0, NO_RES},
        '{0, '0, 0, '{rnmf_pkg::OP_PIXEL, -16'sh8000}, 1, 0, NO_RES},
        '{0, '0, 0, '{rnmf_pkg::OP_FLUSH, 16'sd0}, 1, 1, SINGLE},
        '{1, ADDR_FRAME_SIZE, 2, '{rnmf_pkg::OP_PIXEL, 16'sd0}, 0, 0, NO_RES},
        '{1, ADDR_RING_DEPTH, 7, '{rnmf_pkg::OP_PIXEL, 16'sd0}, 0, 0, NO_RES},
        '{0, '0, 0, '{rnmf_pkg::OP_PIXEL, 16'sh7fff}, 0, 0, NO_RES},
        '{0, '0, 0, '{rnmf_pkg::OP_PIXEL, -16'sh8000}, 0, 0, NO_RES},
        '{0, '0, 0, '{rnmf_pkg::OP_PIXEL, 16'sh7fff}, 0, 0, NO_RES},
        '{0, '0, 0, '{rnmf_pkg::OP_PIXEL, 16'sh7fff}, 0, 0, NO_RES},
        '{0, '0, 0, '{rnmf_pkg::OP_FLUSH, 16'sd0}, 0, 0, NO_RES},
        '{0, '0, 0, '{rnmf_pkg::OP_FLUSH, 16'sd0}, 0, 0, NO_RES},
        '{0, '0, 0, '{rnmf_pkg::OP_FLUSH, 16'sd0}, 0, 0, NO_RES},
        '{0, '0, 0, '{rnmf_pkg::OP_FLUSH, 16'sd0}, 0, 0, NO_RES},
        '{0, '0, 0, '{rnmf_pkg::OP_FLUSH, 16'sd0}, 0, 0, NO_RES}
    };

    function automatic int unsigned eff_depth();
        if (depth_reg == 0) return 1;
        if (depth_reg > rnmf_pkg::MAX_DEPTH_DEF) return rnmf_pkg::MAX_DEPTH_DEF;
        return depth_reg;
    endfunction

    function automatic int unsigned eff_size();
        if (size_reg == 0) return 1;
        if (size_reg > rnmf_pkg::MAX_FRAME_DEF) return rnmf_pkg::MAX_FRAME_DEF;
        return size_reg;
    endfunction

    function automatic void clear_positions();
        in_row = 0;
        in_col = 0;
        out_row = 0;
        out_col = 0;
    endfunction

    function automatic longint neighbour_at(int r, int c, int sz);
        if (r < 0 || c < 0 || r >= sz || c >= sz) return 0;
        return line_rows[r % RING_ROWS][c];
    endfunction

    function automatic rnmf_pkg::t_out_item next_mean();
        int sz;
        int d;
        longint total;
        rnmf_pkg::t_out_item res;
        sz = eff_size();
        d = eff_depth();
        total = 0;
        for (int k = 1; k <= d; k++) begin
            for (int dr = -1; dr <= 1; dr++) begin
                for (int dc = -1; dc <= 1; dc++) begin
                    if (dr != 0 || dc != 0) begin
                        total += neighbour_at(out_row + dr * k, out_col + dc * k, sz);
                    end
                end
            end
        end
        res.mean_value = 16'(total / (8 * d));
        res.centre_row = out_row[7:0];
        res.centre_col = out_col[7:0];
        res.frame_last = (out_row == sz - 1) && (out_col == sz - 1);
        if (res.frame_last) begin
            clear_positions();
            frame_done = 1;
        end else if (++out_col >= sz) begin
            out_col = 0;
            out_row++;
        end
        return res;
    endfunction

    function automatic bit filter_item(rnmf_pkg::t_in_item item,
                                       output rnmf_pkg::t_out_item res);
        int unsigned sz;
        int unsigned row;
        sz = eff_size();
        res = NO_RES;
        if (item.operation == rnmf_pkg::OP_FLUSH) begin
            if (in_row >= sz && out_row < sz) begin
                res = next_mean();
                return 1;
            end
            return 0;
        end
        if (in_row >= sz) return 0;
        row = in_row;
        line_rows[row % RING_ROWS][in_col] = item.pixel;
        if (++in_col >= sz) begin
            in_col = 0;
            in_row++;
        end
        if (row >= eff_depth() + 1) begin
            res = next_mean();
            return 1;
        end
        return 0;
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $time);
        errors++;
    endtask

    task automatic write_reg(logic [rnmf_pkg::CFG_ADDR_W-1:0] addr, int unsigned value);
        while (pending_means.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= addr;
        pwdata <= {8'($urandom_range(0, 255)), 24'h0} | value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_RING_DEPTH) depth_reg = value[rnmf_pkg::DEPTH_REG_W-1:0];
        else size_reg = value[rnmf_pkg::SIZE_REG_W-1:0];
        clear_positions();
    endtask

    task automatic send_item(rnmf_pkg::t_in_item item, output bit has,
                             output rnmf_pkg::t_out_item res);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= item;
        do @(posedge i_clk); while (!o_in_ready);
        has = filter_item(item, res);
        n_items++;
    endtask

    task automatic push_item(rnmf_pkg::t_in_item item);
        bit has;
        rnmf_pkg::t_out_item res;
        send_item(item, has, res);
        if (has) pending_means.push_back(res);
    endtask

    function automatic logic signed [rnmf_pkg::PIXEL_BITS-1:0] pick_pixel();
        case ($urandom_range(0, 7))
            0: return 16'sh7fff;
            1: return -16'sh8000;
            2: return 16'sd0;
            default: return 16'($urandom);
        endcase
    endfunction

    always @(posedge i_clk) begin
        rnmf_pkg::t_out_item want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b1;
            ready_wait = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (pending_means.size() == 0) begin
                    report("unexpected result transfer", 1, 0);
                end else begin
                    want = pending_means.pop_front();
                    if (o_out_data.mean_value !== want.mean_value)
                        report("mean_value", o_out_data.mean_value, want.mean_value);
                    if (o_out_data.centre_row !== want.centre_row)
                        report("centre_row", o_out_data.centre_row, want.centre_row);
                    if (o_out_data.centre_col !== want.centre_col)
                        report("centre_col", o_out_data.centre_col, want.centre_col);
                    if (o_out_data.frame_last !== want.frame_last)
                        report("frame_last", o_out_data.frame_last, want.frame_last);
                end
                ready_wait = calm ? 0 : $urandom_range(0, 9);
                if (ready_wait > 0) i_out_ready <= 1'b0;
            end else if (!i_out_ready) begin
                ready_wait--;
                if (ready_wait <= 0) i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || psel) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT) begin
            $display("[ring_neighbour_mean_filter] ERROR");
            $finish;
        end
    end

    initial begin
        bit has;
        rnmf_pkg::t_out_item res;
        int frame_items;
        int sz;
        bit quit_early;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        n_items = 0;
        calm = 0;
        depth_reg = 1;
        size_reg = 256;
        clear_positions();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) begin
            if (directed[i].is_cfg) begin
                i_in_valid <= 1'b0;
                write_reg(directed[i].addr, directed[i].value);
            end else begin
                send_item(directed[i].item, has, res);
                if (directed[i].typed) begin
                    if (directed[i].has_res) pending_means.push_back(directed[i].res);
                end else if (has) begin
                    pending_means.push_back(res);
                end
            end
        end

        // Largest frame: only the first rows, enough for four results at the top and left borders.
        i_in_valid <= 1'b0;
        write_reg(ADDR_FRAME_SIZE, 511);
        write_reg(ADDR_RING_DEPTH, 1);
        calm = 1;
        for (int i = 0; i < 2 * rnmf_pkg::MAX_FRAME_DEF + 4; i++)
            push_item('{rnmf_pkg::OP_PIXEL, pick_pixel()});
        calm = 0;

        while (n_items < ITEM_TARGET) begin
            i_in_valid <= 1'b0;
            write_reg(ADDR_RING_DEPTH, $urandom_range(0, 7));
            sz = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(0, 8);
            write_reg(ADDR_FRAME_SIZE, sz);
            calm = ($urandom_range(0, 3) == 0);
            frame_done = 0;
            quit_early = ($urandom_range(0, 19) == 0);
            frame_items = 0;
            while (!frame_done && !(quit_early && frame_items > 5)) begin
                if (in_row < eff_size())
                    push_item('{($urandom_range(0, 9) == 0) ? rnmf_pkg::OP_FLUSH
                                                              : rnmf_pkg::OP_PIXEL,
                                pick_pixel()});
                else
                    push_item('{($urandom_range(0, 4) == 0) ? rnmf_pkg::OP_PIXEL
                                                              : rnmf_pkg::OP_FLUSH,
                                pick_pixel()});
                frame_items++;
            end
            if ($urandom_range(0, 3) == 0) push_item('{rnmf_pkg::OP_FLUSH, pick_pixel()});
        end
        i_in_valid <= 1'b0;
        calm = 0;

        while (pending_means.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (errors == 0 && pending_means.size() == 0) begin
            $display("[ring_neighbour_mean_filter] OK");
        end else begin
            $display("[ring_neighbour_mean_filter] ERROR");
        end
        $finish;
    end

endmodule
